// ===== hdl/ounc_pkg.sv =====
// ----------------------------------------------------------------------------
// ounc_pkg
// Shared constants, register map and configuration type of the
// Ornstein-Uhlenbeck noise current bank.
// ----------------------------------------------------------------------------
package ounc_pkg;

	localparam int MAX_TARGETS = 64;
	localparam int MEM_AW      = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

	localparam int IDX_W    = 6;
	localparam int SMP_W    = 16;
	localparam int AMP_W    = 32;
	localparam int SUM_W    = 40;
	localparam int DECAY_W  = 16;
	localparam int SCALE_W  = 31;
	localparam int PERIOD_W = 16;
	localparam int COUNT_W  = 7;
	localparam int TICK_W   = 32;
	localparam int PROD_W   = 48;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 72;
	localparam int M_TUSER_W = 2;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef enum logic [2:0] {
		REG_DRIFT  = 3'd0,
		REG_DECAY  = 3'd1,
		REG_SCALE  = 3'd2,
		REG_PERIOD = 3'd3,
		REG_COUNT  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [AMP_W-1:0] drift_term;
		logic [DECAY_W-1:0]      decay_factor;
		logic [SCALE_W-1:0]      noise_scale;
		logic [PERIOD_W-1:0]     update_period;
		logic [COUNT_W-1:0]      target_count;
	} cfg_t;

endpackage

// ===== hdl/ounc_regs.sv =====
// ----------------------------------------------------------------------------
// ounc_regs
// APB register file holding drift, decay, noise scale, update period and
// target count.
// ----------------------------------------------------------------------------
module ounc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ounc_pkg::APB_AW-1:0]  paddr,
	input  logic [ounc_pkg::APB_DW-1:0]  pwdata,
	output logic [ounc_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output ounc_pkg::cfg_t               cfg
);
	import ounc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drift_term    <= '0;
			cfg_q.decay_factor  <= '0;
			cfg_q.noise_scale   <= '0;
			cfg_q.update_period <= PERIOD_W'(1);
			cfg_q.target_count  <= COUNT_W'(1);
		end else if (wr_en) begin
			case (sel)
				REG_DRIFT:  cfg_q.drift_term    <= pwdata[AMP_W-1:0];
				REG_DECAY:  cfg_q.decay_factor  <= pwdata[DECAY_W-1:0];
				REG_SCALE:  cfg_q.noise_scale   <= pwdata[SCALE_W-1:0];
				REG_PERIOD: cfg_q.update_period <= pwdata[PERIOD_W-1:0];
				REG_COUNT:  cfg_q.target_count  <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_DRIFT:  prdata = APB_DW'(cfg_q.drift_term);
			REG_DECAY:  prdata = APB_DW'(cfg_q.decay_factor);
			REG_SCALE:  prdata = APB_DW'(cfg_q.noise_scale);
			REG_PERIOD: prdata = APB_DW'(cfg_q.update_period);
			REG_COUNT:  prdata = APB_DW'(cfg_q.target_count);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== hdl/ounc_mac.sv =====
// ----------------------------------------------------------------------------
// ounc_mac
// Bit-serial multiply-add: drift + round(amp*decay) + round(scale*sample),
// one multiplier bit per cycle, then rounding and 32-bit saturation.
// ----------------------------------------------------------------------------
module ounc_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ounc_pkg::AMP_W-1:0]   amp,
	input  logic        [ounc_pkg::DECAY_W-1:0] decay,
	input  logic        [ounc_pkg::SCALE_W-1:0] scale,
	input  logic signed [ounc_pkg::SMP_W-1:0]   sample,
	input  logic signed [ounc_pkg::AMP_W-1:0]   drift,
	output logic                                done,
	output logic signed [ounc_pkg::AMP_W-1:0]   result
);
	import ounc_pkg::*;

	localparam int RA_W  = AMP_W + 1;
	localparam int RN_W  = PROD_W - 12;
	localparam int ADD_W = RN_W + 1;

	typedef enum logic [1:0] {M_IDLE, M_RUN, M_RND, M_ADD} mac_state_t;

	mac_state_t               state_q;
	logic [3:0]               cnt_q;
	logic signed [PROD_W-1:0] ma_q, mn_q, pa_q, pn_q;
	logic [DECAY_W-1:0]       da_q;
	logic [SMP_W-1:0]         sn_q;
	logic signed [RA_W-1:0]   ra_q;
	logic signed [RN_W-1:0]   rn_q;
	logic signed [AMP_W-1:0]  res_q;
	logic                     done_q;

	logic signed [PROD_W-1:0] pa_add, pn_add, pa_rnd, pn_rnd;
	logic signed [ADD_W-1:0]  total;
	logic signed [AMP_W-1:0]  sat_total;

	always_comb begin
		pa_add = da_q[0] ? ma_q : '0;
		pn_add = sn_q[0] ? mn_q : '0;
		pa_rnd = (pa_q + PROD_W'(32768)) >>> 16;
		pn_rnd = (pn_q + PROD_W'(2048)) >>> 12;
		total  = ADD_W'(drift) + ADD_W'(ra_q) + ADD_W'(rn_q);
		if (total > ADD_W'(33'sh0_7FFF_FFFF))
			sat_total = {1'b0, {(AMP_W-1){1'b1}}};
		else if (total < -ADD_W'(33'sh0_8000_0000))
			sat_total = {1'b1, {(AMP_W-1){1'b0}}};
		else
			sat_total = total[AMP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == M_ADD);
			case (state_q)
				M_IDLE: begin
					if (start) begin
						ma_q    <= PROD_W'(amp);
						mn_q    <= PROD_W'({1'b0, scale});
						da_q    <= decay;
						sn_q    <= sample;
						pa_q    <= '0;
						pn_q    <= '0;
						cnt_q   <= '0;
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					pa_q <= pa_q + pa_add;
					if (cnt_q == 4'(SMP_W - 1))
						pn_q <= pn_q - pn_add;
					else
						pn_q <= pn_q + pn_add;
					ma_q  <= ma_q <<< 1;
					mn_q  <= mn_q <<< 1;
					da_q  <= da_q >> 1;
					sn_q  <= sn_q >> 1;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(SMP_W - 1))
						state_q <= M_RND;
				end
				M_RND: begin
					ra_q    <= pa_rnd[RA_W-1:0];
					rn_q    <= pn_rnd[RN_W-1:0];
					state_q <= M_ADD;
				end
				M_ADD: begin
					res_q   <= sat_total;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== hdl/ounc_div.sv =====
// ----------------------------------------------------------------------------
// ounc_div
// Bit-serial restoring divider: signed 40-bit sum over a 7-bit count,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module ounc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ounc_pkg::SUM_W-1:0]   dividend,
	input  logic        [ounc_pkg::COUNT_W-1:0] divisor,
	output logic                                done,
	output logic signed [ounc_pkg::AMP_W-1:0]   quotient
);
	import ounc_pkg::*;

	localparam int CNT_W = $clog2(SUM_W);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} div_state_t;

	div_state_t          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    mag_q;
	logic [COUNT_W-1:0]  d_q, rem_q;
	logic                neg_q, done_q;
	logic signed [AMP_W-1:0] quo_q;

	logic [COUNT_W:0]   trial;
	logic               fits;
	logic [COUNT_W:0]   diff;
	logic signed [AMP_W-1:0] fin;

	always_comb begin
		trial = {rem_q, mag_q[SUM_W-1]};
		fits  = trial >= {1'b0, d_q};
		diff  = trial - {1'b0, d_q};
		if (!neg_q) begin
			if (mag_q > SUM_W'(32'h7FFF_FFFF))
				fin = {1'b0, {(AMP_W-1){1'b1}}};
			else
				fin = mag_q[AMP_W-1:0];
		end else begin
			if (mag_q > SUM_W'(33'h0_8000_0000))
				fin = {1'b1, {(AMP_W-1){1'b0}}};
			else
				fin = -mag_q[AMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == D_FIN);
			case (state_q)
				D_IDLE: begin
					if (start) begin
						neg_q   <= dividend[SUM_W-1];
						mag_q   <= dividend[SUM_W-1] ? -dividend : dividend;
						d_q     <= (divisor == '0) ? COUNT_W'(1) : divisor;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
					mag_q <= {mag_q[SUM_W-2:0], fits};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1))
						state_q <= D_FIN;
				end
				D_FIN: begin
					quo_q   <= fin;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/ou_noise_current_bank_unit.sv =====
// ----------------------------------------------------------------------------
// ou_noise_current_bank_unit
// Ornstein-Uhlenbeck noise current bank with per-target amplitude store.
//
// Input stream: one transfer per target and tick; s_tlast closes the tick,
// s_tuser is the active flag. Output stream: one transfer per input item
// with the target's amplitude and, on an active closing item, the mean.
// Configuration goes through the APB port; the user is to write it only
// while the block is idle, as the block itself does not enforce this.
// On an update tick the bit-serial multiply-add walks the 16 multiplier
// bits, and on the closing item of an active tick the bit-serial divider
// walks the 40 sum bits. One item is worked on at a time; a new item is
// taken while the previous result waits in the output register. A stalled
// receiver holds the result register, and the block then holds the
// following item before delivery. Reset returns the configuration
// registers to their defaults, clears the tick counters, the sum and the
// amplitude store (valid bits), and the block is ready at once.
// ----------------------------------------------------------------------------
module ou_noise_current_bank_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ounc_pkg::S_TDATA_W-1:0]  s_tdata,  // target_index, noise_sample
	input  logic                            s_tuser,  // active
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ounc_pkg::M_TDATA_W-1:0]  m_tdata,  // out_target, amplitude, mean_current
	output logic [ounc_pkg::M_TUSER_W-1:0]  m_tuser,  // delivered, mean_valid
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ounc_pkg::APB_AW-1:0]     paddr,
	input  logic [ounc_pkg::APB_DW-1:0]     pwdata,
	output logic [ounc_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);
	import ounc_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MAC, S_SUM, S_DIV, S_OUT} state_t;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	cfg_t cfg;

	state_t                  state_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    act_q, last_q, due_q, stored_q, hit_q;
	logic signed [SMP_W-1:0] smp_q;
	logic signed [AMP_W-1:0] amp_q, rd_q, mean_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [TICK_W-1:0]       tick_q, next_tick_q;
	logic [MAX_TARGETS-1:0]  valid_q;
	logic                    mac_start_q, div_start_q;
	logic                    m_tvalid_q;
	logic [M_TDATA_W-1:0]    m_tdata_q;
	logic [M_TUSER_W-1:0]    m_tuser_q;

	logic signed [AMP_W-1:0] amp_mem [MAX_TARGETS];

	logic                    accept;
	logic [IDX_W-1:0]        s_idx;
	logic [MEM_AW-1:0]       s_addr, w_addr;
	logic                    s_stored;
	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] sum_next;
	logic                    mac_done, div_done;
	logic signed [AMP_W-1:0] mac_res, div_res;
	logic                    out_free;

	ounc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ounc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start_q),
		.amp    (amp_q),
		.decay  (cfg.decay_factor),
		.scale  (cfg.noise_scale),
		.sample (smp_q),
		.drift  (cfg.drift_term),
		.done   (mac_done),
		.result (mac_res)
	);

	ounc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_q),
		.divisor  (cfg.target_count),
		.done     (div_done),
		.quotient (div_res)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign s_idx    = s_tdata[IDX_W-1:0];
	assign s_addr   = MEM_AW'(s_idx);
	assign w_addr   = MEM_AW'(idx_q);
	assign s_stored = 32'(s_idx) < MAX_TARGETS;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(amp_q);
		if (sum_wide > (SUM_W+1)'(SUM_MAX))
			sum_next = SUM_MAX;
		else if (sum_wide < (SUM_W+1)'(SUM_MIN))
			sum_next = SUM_MIN;
		else
			sum_next = sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= amp_mem[s_addr];
		if (state_q == S_MAC && mac_done)
			amp_mem[w_addr] <= mac_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			hit_q       <= 1'b0;
			sum_q       <= '0;
			tick_q      <= '0;
			next_tick_q <= '0;
			mac_start_q <= 1'b0;
			div_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			mac_start_q <= (state_q == S_LOAD) && act_q && stored_q && due_q;
			div_start_q <= (state_q == S_SUM) && act_q && last_q;
			if (m_tready && !(state_q == S_OUT && out_free))
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q    <= s_idx;
						smp_q    <= s_tdata[IDX_W +: SMP_W];
						act_q    <= s_tuser;
						last_q   <= s_tlast;
						stored_q <= s_stored;
						hit_q    <= valid_q[s_addr];
						due_q    <= tick_q >= next_tick_q;
						state_q  <= S_LOAD;
					end
				end
				S_LOAD: begin
					amp_q  <= (stored_q && hit_q) ? rd_q : '0;
					mean_q <= '0;
					if (act_q && stored_q && due_q)
						state_q <= S_MAC;
					else
						state_q <= S_SUM;
				end
				S_MAC: begin
					if (mac_done) begin
						amp_q           <= mac_res;
						valid_q[w_addr] <= 1'b1;
						state_q         <= S_SUM;
					end
				end
				S_SUM: begin
					if (act_q && stored_q)
						sum_q <= sum_next;
					if (act_q && last_q)
						state_q <= S_DIV;
					else
						state_q <= S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						mean_q  <= div_res;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {(M_TDATA_W - IDX_W - 2*AMP_W)'(0), mean_q, amp_q, idx_q};
						m_tuser_q  <= {act_q && last_q, act_q && stored_q};
						if (last_q) begin
							if (act_q && due_q)
								next_tick_q <= tick_q + TICK_W'(cfg.update_period);
							tick_q <= tick_q + TICK_W'(1);
							sum_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	a_mean_implies_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
		else $error("mean flagged on an undelivered item");

	a_mean_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[IDX_W+AMP_W +: AMP_W] == '0))
		else $error("mean field not zero without mean flag");

	a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == S_MAC))
		else $error("multiply-add finished outside its wait state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	a_tick_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q != $past(tick_q)) |-> $past(state_q == S_OUT && last_q && out_free))
		else $error("tick count moved without a closing item");
`endif

endmodule
